### rtl/sins_pkg.sv
package sins_pkg;

  // request payloads
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] nav_accel_x;
    logic signed [31:0] nav_accel_y;
    logic signed [31:0] nav_accel_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic               stationary;
  } out_req_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // sequencer step numbers
  localparam int StepW = 6;
  typedef logic [StepW-1:0] step_t;

  localparam step_t S_DIV   = 6'd0;   // three reciprocal multiplies for /10
  localparam step_t S_SCL   = 6'd3;   // count * count_gain
  localparam step_t S_CMP   = 6'd6;   // (a - offset) * gain
  localparam step_t S_PP    = 6'd9;   // nine quaternion products
  localparam step_t S_MAT   = 6'd19;  // matrix elements from products
  localparam step_t S_ROT   = 6'd20;  // nine matrix * vector products
  localparam step_t S_NAV2  = 6'd30;  // finish z row
  localparam step_t S_GRAV  = 6'd31;  // gravity removal
  localparam step_t S_DB    = 6'd32;  // deadband and stationary flag
  localparam step_t S_VEL   = 6'd33;  // nav * dt
  localparam step_t S_POS   = 6'd36;  // vel * dt
  localparam step_t S_LAST  = 6'd39;

  // command from controller to datapath
  typedef struct packed {
    logic  load;
    logic  step_en;
    step_t step;
  } cmd_t;

  // register indexes
  localparam logic [2:0] REG_COUNT_GAIN = 3'd0;
  localparam logic [2:0] REG_OFFSET_X   = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd2;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd3;
  localparam logic [2:0] REG_GAIN_X     = 3'd4;
  localparam logic [2:0] REG_GAIN_Y     = 3'd5;
  localparam logic [2:0] REG_GAIN_Z     = 3'd6;

  // arithmetic constants
  localparam logic signed [25:0] RECIP10   = 26'sd52429;    // 2^19 / 10, rounded up
  localparam logic signed [25:0] DT_Q32    = 26'sd21474836;
  localparam logic signed [63:0] GRAV_BIAS = 64'sd649124;
  localparam logic signed [31:0] DBX_LIM   = 32'sd1310;
  localparam logic signed [31:0] DBYZ_LIM  = 32'sd1966;
  localparam logic signed [34:0] ONE_Q28   = 35'sd268435456;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd549755813887;
    lo = -64'sd549755813888;
    if (v > hi) return 40'sh7fffffffff;
    else if (v < lo) return 40'sh8000000000;
    else return v[39:0];
  endfunction

  // column of matrix element k (row-major)
  function automatic logic [1:0] col_of(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

endpackage

### rtl/sins_ctrl.sv
module sins_ctrl import sins_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // state and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.step_en = 1'b0;
    cmd.step    = step_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        cmd.step_en = 1'b1;
        if (step_r == S_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/sins_dp.sv
module sins_dp import sins_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  in_req_t     in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output out_req_t    out_data
);

  // configuration registers
  logic        [23:0] count_gain_r;
  logic signed [31:0] offset_r [3];
  logic        [15:0] gain_r   [3];

  // working registers
  in_req_t            in_r;
  logic signed [16:0] t_r   [3];
  logic signed [31:0] c_r   [3];
  logic signed [31:0] acc_r [3];
  logic signed [31:0] pp_r  [9];
  logic signed [20:0] m_r   [9];
  logic signed [55:0] sum_r;
  logic signed [31:0] nav_r [3];
  logic               still_r;
  logic signed [31:0] vel_r [3];
  logic signed [39:0] pos_r [3];
  logic signed [58:0] prod_r;

  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [15:0] raw [3];
  logic signed [15:0] q   [4];
  logic        [1:0]  ai;
  logic        [3:0]  pk;
  logic        [3:0]  rk;
  logic        [3:0]  ck;

  // payload views
  assign raw[0] = in_r.raw_accel_x;
  assign raw[1] = in_r.raw_accel_y;
  assign raw[2] = in_r.raw_accel_z;
  assign q[0]   = in_r.quat_w;
  assign q[1]   = in_r.quat_x;
  assign q[2]   = in_r.quat_y;
  assign q[3]   = in_r.quat_z;

  // matrix element whose product is consumed this step
  assign ck = 4'(cmd.step - (S_ROT + 6'd1));

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_gain_r <= 24'd40168;
      offset_r[0]  <= '0;
      offset_r[1]  <= '0;
      offset_r[2]  <= '0;
      gain_r[0]    <= 16'd16384;
      gain_r[1]    <= 16'd16384;
      gain_r[2]    <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_GAIN: count_gain_r <= cfg_wdata[23:0];
        REG_OFFSET_X:   offset_r[0]  <= cfg_wdata;
        REG_OFFSET_Y:   offset_r[1]  <= cfg_wdata;
        REG_OFFSET_Z:   offset_r[2]  <= cfg_wdata;
        REG_GAIN_X:     gain_r[0]    <= cfg_wdata[15:0];
        REG_GAIN_Y:     gain_r[1]    <= cfg_wdata[15:0];
        REG_GAIN_Z:     gain_r[2]    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ai    = '0;
    pk    = 4'(cmd.step - S_PP);
    rk    = 4'(cmd.step - S_ROT);
    case (cmd.step) inside
      [S_DIV:S_DIV+2]: begin
        ai    = 2'(cmd.step - S_DIV);
        mul_a = raw[ai][15] ? -33'(raw[ai]) : 33'(raw[ai]);
        mul_b = RECIP10;
      end
      [S_SCL:S_SCL+2]: begin
        ai    = 2'(cmd.step - S_SCL);
        mul_a = 33'(t_r[ai]);
        mul_b = $signed({2'b00, count_gain_r});
      end
      [S_CMP:S_CMP+2]: begin
        ai    = 2'(cmd.step - S_CMP);
        mul_a = 33'(c_r[ai]);
        mul_b = $signed({10'd0, gain_r[ai]});
      end
      [S_PP:S_PP+8]: begin
        case (pk)
          4'd0: begin mul_a = 33'(q[1]); mul_b = 26'(q[1]); end
          4'd1: begin mul_a = 33'(q[2]); mul_b = 26'(q[2]); end
          4'd2: begin mul_a = 33'(q[3]); mul_b = 26'(q[3]); end
          4'd3: begin mul_a = 33'(q[1]); mul_b = 26'(q[2]); end
          4'd4: begin mul_a = 33'(q[0]); mul_b = 26'(q[3]); end
          4'd5: begin mul_a = 33'(q[1]); mul_b = 26'(q[3]); end
          4'd6: begin mul_a = 33'(q[0]); mul_b = 26'(q[2]); end
          4'd7: begin mul_a = 33'(q[2]); mul_b = 26'(q[3]); end
          default: begin mul_a = 33'(q[0]); mul_b = 26'(q[1]); end
        endcase
      end
      [S_ROT:S_ROT+8]: begin
        mul_a = 33'(acc_r[col_of(rk)]);
        mul_b = 26'(m_r[rk]);
      end
      [S_VEL:S_VEL+2]: begin
        ai    = 2'(cmd.step - S_VEL);
        mul_a = 33'(nav_r[ai]);
        mul_b = DT_Q32;
      end
      [S_POS:S_POS+2]: begin
        ai    = 2'(cmd.step - S_POS);
        mul_a = 33'(vel_r[ai]);
        mul_b = DT_Q32;
      end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (cmd.step_en) prod_r <= 59'(mul_a * mul_b);
  end

  // load request and consume products
  always_ff @(posedge clk) begin
    logic        [11:0] qd;
    logic signed [16:0] q10;
    logic signed [31:0] sv;
    logic signed [34:0] e [9];
    logic signed [31:0] n2;
    logic        [1:0]  bi;
    bi = '0;
    qd = prod_r[30:19];
    q10 = $signed({2'b00, qd, 3'b000}) + $signed({4'b0000, qd, 1'b0});
    if (!rst_n) begin
      vel_r[0] <= '0; vel_r[1] <= '0; vel_r[2] <= '0;
      pos_r[0] <= '0; pos_r[1] <= '0; pos_r[2] <= '0;
    end else if (cmd.load) begin
      in_r <= in_data;
    end else if (cmd.step_en) begin
      case (cmd.step) inside
        [S_DIV+1:S_DIV+3]: begin
          bi = 2'(cmd.step - (S_DIV + 6'd1));
          t_r[bi] <= raw[bi][15] ? -q10 : q10;
        end
        [S_SCL+1:S_SCL+3]: begin
          bi = 2'(cmd.step - (S_SCL + 6'd1));
          sv = sat32(64'((prod_r + 59'sd128) >>> 8));
          c_r[bi] <= sat32(64'(sv) - 64'(offset_r[bi]));
        end
        [S_CMP+1:S_CMP+3]: begin
          bi = 2'(cmd.step - (S_CMP + 6'd1));
          acc_r[bi] <= sat32(64'((prod_r + 59'sd8192) >>> 14));
        end
        [S_PP+1:S_PP+9]: begin
          pp_r[4'(cmd.step - (S_PP + 6'd1))] <= prod_r[31:0];
        end
        S_MAT: begin
          // products: xx yy zz xy wz xz wy yz wx
          e[0] = ONE_Q28 - 35'((64'(pp_r[1]) + 64'(pp_r[2])) <<< 1);
          e[1] = 35'((64'(pp_r[3]) - 64'(pp_r[4])) <<< 1);
          e[2] = 35'((64'(pp_r[5]) + 64'(pp_r[6])) <<< 1);
          e[3] = 35'((64'(pp_r[3]) + 64'(pp_r[4])) <<< 1);
          e[4] = ONE_Q28 - 35'((64'(pp_r[0]) + 64'(pp_r[2])) <<< 1);
          e[5] = 35'((64'(pp_r[7]) - 64'(pp_r[8])) <<< 1);
          e[6] = 35'((64'(pp_r[5]) - 64'(pp_r[6])) <<< 1);
          e[7] = 35'((64'(pp_r[7]) + 64'(pp_r[8])) <<< 1);
          e[8] = ONE_Q28 - 35'((64'(pp_r[0]) + 64'(pp_r[1])) <<< 1);
          for (int i = 0; i < 9; i++) begin
            m_r[i] <= 21'((e[i] + 35'sd8192) >>> 14);
          end
        end
        [S_ROT+1:S_ROT+9]: begin
          if (col_of(ck) == 2'd0) begin
            sum_r <= 56'(prod_r);
            if (ck == 4'd3) nav_r[0] <= sat32(64'((sum_r + 56'sd8192) >>> 14));
            if (ck == 4'd6) nav_r[1] <= sat32(64'((sum_r + 56'sd8192) >>> 14));
          end else begin
            sum_r <= sum_r + 56'(prod_r);
          end
        end
        S_NAV2: nav_r[2] <= sat32(64'((sum_r + 56'sd8192) >>> 14));
        S_GRAV: nav_r[2] <= sat32(64'(nav_r[2]) - GRAV_BIAS);
        S_DB: begin
          logic zx, zy, zz;
          zx = (nav_r[0] >= -DBX_LIM) && (nav_r[0] <= DBX_LIM);
          zy = (nav_r[1] >= -DBYZ_LIM) && (nav_r[1] <= DBYZ_LIM);
          zz = (nav_r[2] >= -DBYZ_LIM) && (nav_r[2] <= DBYZ_LIM);
          if (zx) nav_r[0] <= '0;
          if (zy) nav_r[1] <= '0;
          if (zz) nav_r[2] <= '0;
          still_r <= zx && zy && zz;
        end
        [S_VEL+1:S_VEL+3]: begin
          bi = 2'(cmd.step - (S_VEL + 6'd1));
          vel_r[bi] <= still_r ? 32'sd0 :
            sat32(64'(vel_r[bi]) + 64'((prod_r + 59'sh80000000) >>> 32));
        end
        [S_POS+1:S_POS+3]: begin
          bi = 2'(cmd.step - (S_POS + 6'd1));
          pos_r[bi] <= sat40(64'(pos_r[bi]) + 64'((prod_r + 59'sh80000000) >>> 32));
        end
        default: ;
      endcase
    end
  end

  // result request
  assign out_data.nav_accel_x = nav_r[0];
  assign out_data.nav_accel_y = nav_r[1];
  assign out_data.nav_accel_z = nav_r[2];
  assign out_data.vel_x       = vel_r[0];
  assign out_data.vel_y       = vel_r[1];
  assign out_data.vel_z       = vel_r[2];
  assign out_data.pos_x       = pos_r[0];
  assign out_data.pos_y       = pos_r[1];
  assign out_data.pos_z       = pos_r[2];
  assign out_data.stationary  = still_r;

endmodule

### rtl/strapdown_ins_integrator_top.sv
// Strapdown navigation integrator: one request per 5 ms tick carries an attitude
// quaternion and three raw accelerometer counts; the block scales and compensates
// the counts, rotates them to the navigation frame, removes gravity, applies a
// deadband, and integrates velocity (cleared when stationary) and position in
// saturating fixed point. The request is latched at its accept edge and run through
// 40 sequencer steps on a single shared 33x26 multiplier, and the result is then
// presented and held until taken. The next request is accepted the cycle after
// the result is taken; none is accepted while a request is in flight or its result
// waits. Configuration writes are taken any time the block is idle; indexes beyond
// 6 are ignored.
module strapdown_ins_integrator_top import sins_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t cmd;

  // sequencer
  sins_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic and state
  sins_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule
